/* sv/rtt_pkg.sv */
// Shared types and constants of the repeating timer table.
`timescale 1ns / 1ps
package rtt_pkg;

    localparam int ID_W        = 4;
    localparam int IVL_W       = 32;
    localparam int NOW_W       = 48;
    localparam int DUE_W       = 49;
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_SET  = 2'd0,
        OP_KILL = 2'd1,
        OP_TICK = 2'd2
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [ID_W-1:0]  id;
        logic [IVL_W-1:0] interval;
        logic [NOW_W-1:0] now;
    } t_cmd;

endpackage

/* sv/repeating_timer_table.sv */
// Top level of the repeating timer table.
//  channel | dir | handshake              | payload
//  s       | in  | i_s_tvalid/o_s_tready  | tuser: operation; tdata: id, interval, now
//  m       | out | o_m_tvalid/i_m_tready  | tdata: fired id; tlast: final id of a tick
// Set and kill are applied in the idle state as they are taken; a tick goes
// through start, scan and flush, scanning one entry per cycle over the entry
// store (one read and one write port) unless a held output stalls it. Reset is
// synchronous and clears all armed bits at once. Requests queue ahead of the engine while it scans.
`timescale 1ns / 1ps
module repeating_timer_table #(
    parameter int TIMER_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [87:0] i_s_tdata,   // [3:0] timer_id, [35:4] interval_ms, [83:36] now_ms
    input  logic [1:0]  i_s_tuser,   // [1:0] operation
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [3:0] fired_id
    output logic        o_m_tlast
);
    import rtt_pkg::*;

    logic            f_valid;
    logic            f_ready;
    t_cmd            f_cmd;
    logic            q_valid;
    logic            q_ready;
    t_cmd            q_cmd;
    logic [ID_W-1:0] fired_id;

    rtt_front #(.TIMER_COUNT(TIMER_COUNT)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_op       (i_s_tuser),
        .i_id       (i_s_tdata[3:0]),
        .i_interval (i_s_tdata[35:4]),
        .i_now      (i_s_tdata[83:36]),
        .o_valid    (f_valid),
        .i_ready    (f_ready),
        .o_cmd      (f_cmd)
    );

    rtt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_cmd   (f_cmd),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_cmd   (q_cmd)
    );

    rtt_back #(.TIMER_COUNT(TIMER_COUNT)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .o_q_ready  (q_ready),
        .i_q_cmd    (q_cmd),
        .o_m_valid  (o_m_tvalid),
        .i_m_ready  (i_m_tready),
        .o_fired_id (fired_id),
        .o_last     (o_m_tlast)
    );

    assign o_m_tdata = {4'd0, fired_id};

endmodule

/* sv/rtt_front.sv */
// Input stage: accept requests, drop ignored ones, register the command.
`timescale 1ns / 1ps
module rtt_front #(
    parameter int TIMER_COUNT = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_op,
    input  logic [rtt_pkg::ID_W-1:0]   i_id,
    input  logic [rtt_pkg::IVL_W-1:0]  i_interval,
    input  logic [rtt_pkg::NOW_W-1:0]  i_now,
    output logic                       o_valid,
    input  logic                       i_ready,
    output rtt_pkg::t_cmd              o_cmd
);
    import rtt_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    logic id_ok;
    logic keep;

    assign id_ok   = 32'(i_id) < TIMER_COUNT;
    assign keep    = (i_op == OP_TICK) || ((i_op == OP_SET || i_op == OP_KILL) && id_ok);
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid && keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd.op       <= t_op'(i_op);
            r_cmd.id       <= i_id;
            r_cmd.interval <= i_interval;
            r_cmd.now      <= i_now;
        end
    end

endmodule

/* sv/rtt_queue.sv */
// Short command queue between the input stage and the timer engine.
`timescale 1ns / 1ps
module rtt_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rtt_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output rtt_pkg::t_cmd o_cmd
);
    import rtt_pkg::*;

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_ready = r_count != CNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_slot[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* sv/rtt_back.sv */
// Timer engine: entry store, tick scan and fired id output register.
`timescale 1ns / 1ps
module rtt_back #(
    parameter int TIMER_COUNT = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_valid,
    output logic                     o_q_ready,
    input  rtt_pkg::t_cmd            i_q_cmd,
    output logic                     o_m_valid,
    input  logic                     i_m_ready,
    output logic [rtt_pkg::ID_W-1:0] o_fired_id,
    output logic                     o_last
);
    import rtt_pkg::*;

    localparam int IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_START = 4'b0010,
        S_SCAN  = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    t_state             r_state;
    logic [TIMER_COUNT-1:0] r_armed;
    logic [IW-1:0]      r_idx;
    logic [NOW_W-1:0]   r_now;
    logic               r_pend_valid;
    logic [IW-1:0]      r_pend_id;
    logic               r_out_valid;
    logic [ID_W-1:0]    r_out_id;
    logic               r_out_last;
    logic [IVL_W-1:0]   r_rd_ivl;
    logic [DUE_W-1:0]   r_rd_due;
    logic [IVL_W-1:0]   r_ivl_mem [TIMER_COUNT];
    logic [DUE_W-1:0]   r_due_mem [TIMER_COUNT];

    logic               take;
    logic               out_free;
    logic               fire;
    logic               stall;
    logic               advance;
    logic               last_idx;
    logic               set_we;
    logic               scan_we;
    logic [IW-1:0]      wr_addr;
    logic [DUE_W-1:0]   wr_due;
    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    logic               out_load;
    logic [IW-1:0]      out_id;
    logic               out_last;

    assign o_q_ready = r_state == S_IDLE;
    assign take      = i_q_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || i_m_ready;
    assign fire      = (r_state == S_SCAN) && r_armed[r_idx]
                       && ({1'b0, r_now} >= r_rd_due);
    assign stall     = fire && r_pend_valid && !out_free;
    assign advance   = (r_state == S_SCAN) && !stall;
    assign last_idx  = r_idx == IW'(TIMER_COUNT - 1);

    assign set_we  = take && (i_q_cmd.op == OP_SET);
    assign scan_we = fire && !stall;
    assign wr_addr = set_we ? IW'(i_q_cmd.id) : r_idx;
    assign wr_due  = set_we ? ({1'b0, i_q_cmd.now} + {17'd0, i_q_cmd.interval})
                            : ({1'b0, r_now} + {17'd0, r_rd_ivl});

    assign rd_en   = (r_state == S_START) || (advance && !last_idx);
    assign rd_addr = (r_state == S_START) ? '0 : r_idx + 1'b1;

    always_comb begin
        out_load = 1'b0;
        out_id   = r_pend_id;
        out_last = 1'b0;
        if (scan_we && r_pend_valid) begin
            out_load = 1'b1;
        end else if ((r_state == S_FLUSH) && r_pend_valid && out_free) begin
            out_load = 1'b1;
            out_last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (set_we || scan_we) begin
            r_due_mem[wr_addr] <= wr_due;
        end
        if (set_we) begin
            r_ivl_mem[wr_addr] <= i_q_cmd.interval;
        end
        if (rd_en) begin
            r_rd_ivl <= r_ivl_mem[rd_addr];
            r_rd_due <= r_due_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_armed      <= '0;
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        unique case (i_q_cmd.op)
                            OP_SET:  r_armed[IW'(i_q_cmd.id)] <= 1'b1;
                            OP_KILL: r_armed[IW'(i_q_cmd.id)] <= 1'b0;
                            OP_TICK: r_state <= S_START;
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_START: begin
                    r_idx   <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (advance) begin
                        if (fire) begin
                            r_pend_valid <= 1'b1;
                            r_pend_id    <= r_idx;
                        end
                        if (last_idx) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_FLUSH: begin
                    if (!r_pend_valid || out_free) begin
                        r_pend_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && (i_q_cmd.op == OP_TICK)) begin
            r_now <= i_q_cmd.now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_id   <= ID_W'(out_id);
            r_out_last <= out_last;
        end
    end

    assign o_m_valid  = r_out_valid;
    assign o_fired_id = r_out_id;
    assign o_last     = r_out_last;

`ifndef SYNTHESIS
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_valid)
        else $error("pending fired id left over in idle");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || i_m_ready))
        else $error("output register overwritten while held");

    a_flush_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |=> (r_state == S_FLUSH || r_state == S_IDLE))
        else $error("flush left to a scan state");
`endif

endmodule

/* verif/tb_repeating_timer_table.sv */
// Self-checking testbench for the repeating timer table: directed table plus random traffic.
`timescale 1ns / 1ps
module tb_repeating_timer_table;
    import rtt_pkg::*;

    localparam int            TIMERS      = 16;
    localparam int            PHASE_ITEMS = 90;
    localparam int            HOLD_CYCLES = 300;
    localparam int            CYCLE_LIMIT = 400000;
    localparam int            MAX_REPORTS = 10;
    localparam logic [1:0]    OP_UNUSED   = 2'd3;
    localparam logic [47:0]   NOW_MAX     = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  id;
        logic [31:0] interval;
        logic [47:0] now;
        logic        typed;
        logic [15:0] fired_mask;
    } t_row;

    typedef struct packed {
        logic [3:0] id;
        logic       last;
    } t_fire;

    localparam int DIR_ROWS = 21;
    t_row dir_rows [DIR_ROWS] = '{
        '{OP_TICK,   4'd0,  32'd0,          48'd0,    1'b1, 16'h0000},
        '{OP_TICK,   4'd0,  32'd0,          NOW_MAX,  1'b1, 16'h0000},
        '{OP_SET,    4'd0,  32'd0,          48'd100,  1'b1, 16'h0000},
        '{OP_TICK,   4'd0,  32'd0,          48'd100,  1'b1, 16'h0001},
        '{OP_TICK,   4'd0,  32'd0,          48'd100,  1'b1, 16'h0001},
        '{OP_SET,    4'd15, 32'hFFFF_FFFF,  NOW_MAX,  1'b1, 16'h0000},
        '{OP_TICK,   4'd0,  32'd0,          NOW_MAX,  1'b1, 16'h0001},
        '{OP_SET,    4'd5,  32'd10,         48'd200,  1'b0, 16'h0000},
        '{OP_SET,    4'd5,  32'd3,          48'd200,  1'b0, 16'h0000},
        '{OP_TICK,   4'd0,  32'd0,          48'd203,  1'b0, 16'h0000},
        '{OP_KILL,   4'd7,  32'd0,          48'd0,    1'b0, 16'h0000},
        '{OP_KILL,   4'd0,  32'd0,          48'd0,    1'b0, 16'h0000},
        '{OP_UNUSED, 4'd5,  32'd0,          48'd1000, 1'b1, 16'h0000},
        '{OP_TICK,   4'd0,  32'd0,          48'd1000, 1'b0, 16'h0000},
        '{OP_SET,    4'd10, 32'd1,          48'd1000, 1'b0, 16'h0000},
        '{OP_TICK,   4'd0,  32'd0,          48'd1000, 1'b0, 16'h0000},
        '{OP_TICK,   4'd0,  32'd0,          48'd1001, 1'b0, 16'h0000},
        '{OP_KILL,   4'd5,  32'd0,          48'd1001, 1'b0, 16'h0000},
        '{OP_KILL,   4'd10, 32'd0,          48'd1001, 1'b0, 16'h0000},
        '{OP_KILL,   4'd15, 32'd0,          48'd1001, 1'b0, 16'h0000},
        '{OP_TICK,   4'd0,  32'd0,          NOW_MAX,  1'b1, 16'h0000}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [87:0] i_s_tdata;   // [3:0] timer_id, [35:4] interval_ms, [83:36] now_ms
    logic [1:0]  i_s_tuser;   // [1:0] operation
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;   // [3:0] fired_id
    logic        o_m_tlast;

    bit          armed_tab [TIMERS];
    bit [31:0]   interval_tab [TIMERS];
    bit [48:0]   due_tab [TIMERS];
    t_fire       pending_fires [$];

    int          tx_idle_pct;
    int          rx_stall_pct;
    bit          rx_hold;
    bit          hold_go;
    logic [47:0] clock_ms;
    int unsigned cycle_cnt;
    int unsigned op_cnt [4];
    int unsigned fires_checked;
    int unsigned mismatch_cnt;

    repeating_timer_table #(
        .TIMER_COUNT(TIMERS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [15:0] timer_table_step(input logic [1:0] op,
                                                     input logic [3:0] id,
                                                     input logic [31:0] interval,
                                                     input logic [47:0] now);
        logic [15:0] fired;
        fired = '0;
        case (op)
            OP_SET: begin
                armed_tab[id]    = 1'b1;
                interval_tab[id] = interval;
                due_tab[id]      = {1'b0, now} + interval;
            end
            OP_KILL: begin
                armed_tab[id] = 1'b0;
            end
            OP_TICK: begin
                for (int i = 0; i < TIMERS; i++) begin
                    if (armed_tab[i] && {1'b0, now} >= due_tab[i]) begin
                        due_tab[i] = {1'b0, now} + interval_tab[i];
                        fired[i]   = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        return fired;
    endfunction

    function automatic void queue_fires(input logic [15:0] fired);
        int    top;
        t_fire item;
        top = -1;
        for (int i = 0; i < TIMERS; i++) begin
            if (fired[i]) begin
                top = i;
            end
        end
        for (int i = 0; i < TIMERS; i++) begin
            if (fired[i]) begin
                item.id       = 4'(i);
                item.last     = (i == top);
                pending_fires = {pending_fires, item};
            end
        end
    endfunction

    function automatic void report_mismatch(input string what);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endfunction

    function automatic void check_fire(input logic [3:0] id, input logic last);
        t_fire exp;
        if (pending_fires.size() == 0) begin
            report_mismatch($sformatf("unexpected id %0d last %0b", id, last));
            return;
        end
        exp = pending_fires.pop_front();
        fires_checked++;
        if (id !== exp.id) begin
            report_mismatch($sformatf("fired_id expected %0d got %0d", exp.id, id));
        end
        if (last !== exp.last) begin
            report_mismatch($sformatf("last_fired on id %0d expected %0b got %0b",
                                      exp.id, exp.last, last));
        end
    endfunction

    task automatic send_request(input logic [1:0] op, input logic [3:0] id,
                                input logic [31:0] interval, input logic [47:0] now,
                                input bit typed, input logic [15:0] typed_mask);
        logic [15:0] fired;
        if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {4'd0, now, interval, id};
        do @(posedge i_clk); while (!o_s_tready);
        fired = timer_table_step(op, id, interval, now);
        queue_fires(typed ? typed_mask : fired);
        op_cnt[op]++;
    endtask

    // arm every entry with a zero interval, then tick: one result per entry
    task automatic full_table_tick();
        for (int i = 0; i < TIMERS; i++) begin
            send_request(OP_SET, 4'(i), 32'd0, clock_ms, 1'b0, '0);
        end
        send_request(OP_TICK, 4'($urandom), 32'($urandom), clock_ms, 1'b0, '0);
    endtask

    task automatic random_request(output bit counted);
        logic [1:0]  op;
        logic [31:0] interval;
        int          pick;
        pick     = $urandom_range(0, 99);
        interval = 32'($urandom_range(1, 24));
        case ($urandom_range(0, 19))
            0: interval = 32'd0;
            1: interval = 32'($urandom);
            2: interval = 32'hFFFF_FFFF;
            default: begin
            end
        endcase
        if (pick < 8) begin
            op = 2'($urandom_range(0, 3));
            send_request(op, 4'($urandom), 32'($urandom),
                         {16'($urandom), 32'($urandom)}, 1'b0, '0);
        end else begin
            clock_ms = clock_ms + ((pick < 12) ? 48'($urandom_range(0, 100000))
                                               : 48'($urandom_range(0, 8)));
            pick = $urandom_range(0, 99);
            op   = (pick < 35) ? OP_SET : (pick < 50) ? OP_KILL : OP_TICK;
            send_request(op, 4'($urandom), interval, clock_ms, 1'b0, '0);
        end
        counted = (op != OP_UNUSED);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                check_fire(o_m_tdata[3:0], o_m_tlast);
            end
            i_m_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // hold off the output side long enough for the block to back up
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d ids outstanding",
                 cycle_cnt, pending_fires.size());
        $display("FAIL");
        $finish;
    end

    initial begin
        int unsigned sent;
        bit          counted;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tuser  <= '0;
        i_s_tdata  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            send_request(dir_rows[r].op, dir_rows[r].id, dir_rows[r].interval,
                         dir_rows[r].now, dir_rows[r].typed, dir_rows[r].fired_mask);
        end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 49; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 49; end
                default: begin tx_idle_pct = 22; rx_stall_pct = 22; end
            endcase
            clock_ms = (phase == 3) ? NOW_MAX - 48'd400 : {16'($urandom), 32'($urandom)};
            if (phase == 0) begin
                hold_go = 1'b1;
            end
            full_table_tick();
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                random_request(counted);
                if (counted) begin
                    sent++;
                end
            end
        end
        i_s_tvalid <= 1'b0;

        while (pending_fires.size() != 0) @(posedge i_clk);
        repeat (2 * TIMERS + 8) @(posedge i_clk);

        $display("Sent %0d sets, %0d kills, %0d ticks, %0d unused codes; four idle/stall mixes,",
                 op_cnt[OP_SET], op_cnt[OP_KILL], op_cnt[OP_TICK], op_cnt[OP_UNUSED]);
        $display("full-table ticks and a long output hold; %0d ids checked in %0d cycles",
                 fires_checked, cycle_cnt);
        if (mismatch_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", mismatch_cnt);
            $display("FAIL");
        end
        $finish;
    end

endmodule
